// File: rtl/core/ddo_pkg.sv
package ddo_pkg;

  localparam int ITER_W = 5;
  localparam int NB_W = 6;

  localparam logic [32:0] K_FULL = 33'd683565276;
  localparam logic [32:0] K_HALF = 33'd341782638;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032875;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_INV_SEP = 2'd1,
    REG_DB_OFFSET = 2'd2,
    REG_DB_WIDTH = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    M_LIN, M_DV, M_ANG, M_RAD, M_DFULL, M_DHALF, M_VX, M_DX, M_VY, M_DY
  } mul_sel_t;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_WAIT, S_CORDIC_INIT, S_CORDIC, S_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_start;
    logic capture;
    mul_sel_t sel;
    logic cordic_init;
    logic cordic_step;
    logic [ITER_W-1:0] iter;
    logic commit;
  } ddo_cmd_t;

  function automatic logic [31:0] atan_bam(input logic [ITER_W-1:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0: r = 32'd536870912;
      5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;
      5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;
      5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;
      5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;
      5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/ddo_mul.sv
module ddo_mul (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [63:0] a,
  input  logic signed [32:0] b,
  input  logic [63:0] init,
  input  logic [ddo_pkg::NB_W-1:0] nbits,
  output logic [63:0] p,
  output logic done
);
  import ddo_pkg::*;

  logic [63:0] acc;
  logic [63:0] a_sh;
  logic signed [32:0] b_sh;
  logic [NB_W-1:0] cnt;
  logic busy;

  // bit-serial shift-add, last bit carries negative weight
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= busy && (cnt == NB_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt <= nbits;
      end else if (busy) begin
        cnt <= cnt - NB_W'(1);
        if (cnt == NB_W'(1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= init;
      a_sh <= a;
      b_sh <= b;
    end else if (busy) begin
      if (b_sh[0]) begin
        if (cnt == NB_W'(1)) acc <= acc - a_sh;
        else acc <= acc + a_sh;
      end
      a_sh <= {a_sh[62:0], 1'b0};
      b_sh <= b_sh >>> 1;
    end
  end

  assign p = acc;

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("multiply started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("done without a finished multiply");

endmodule

// File: rtl/core/ddo_datapath.sv
module ddo_datapath (
  input  logic clk,
  input  logic rst,
  input  ddo_pkg::ddo_cmd_t cmd,
  output logic mul_done,
  input  logic cfg_wen,
  input  logic [1:0] cfg_index,
  input  logic [23:0] cfg_data,
  input  logic signed [23:0] left_wheel_speed,
  input  logic signed [23:0] right_wheel_speed,
  input  logic [15:0] time_step,
  output logic signed [31:0] pose_x,
  output logic signed [31:0] pose_y,
  output logic signed [31:0] heading
);
  import ddo_pkg::*;

  logic [15:0] radius;
  logic [23:0] inv_sep;
  logic signed [16:0] db_offset;
  logic [15:0] db_width;

  logic signed [23:0] wl, wr;
  logic [15:0] dt;
  logic signed [24:0] lin;
  logic signed [25:0] dv;
  logic signed [33:0] ang;
  logic [63:0] rad;
  logic [31:0] dfull, dhalf;
  logic signed [33:0] cx, cy, cz;
  logic cneg;
  logic signed [43:0] vx, vy;
  logic signed [27:0] dx, dy;

  logic [63:0] mul_a, mul_init, mul_p;
  logic signed [32:0] mul_b;
  logic [NB_W-1:0] mul_nb;

  logic signed [24:0] sum_lr, dif_lr;
  logic signed [33:0] cneg_x, cneg_y;
  logic signed [32:0] c_val, s_val;

  // dead band
  function automatic logic signed [23:0] dband(input logic signed [23:0] w,
                                               input logic signed [16:0] off,
                                               input logic [15:0] wd);
    logic signed [25:0] d;
    logic signed [25:0] wds;
    d = {{2{w[23]}}, w} - {{9{off[16]}}, off};
    wds = {10'b0, wd};
    if (d < wds && d > -wds) return '0;
    return w;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= 16'd5243;
      inv_sep <= 24'd136533;
      db_offset <= 17'sd7;
      db_width <= 16'd66;
    end else if (cfg_wen) begin
      unique case (reg_idx_t'(cfg_index))
        REG_RADIUS: radius <= cfg_data[15:0];
        REG_INV_SEP: inv_sep <= cfg_data;
        REG_DB_OFFSET: db_offset <= cfg_data[16:0];
        REG_DB_WIDTH: db_width <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign sum_lr = {wl[23], wl} + {wr[23], wr};
  assign dif_lr = {wr[23], wr} - {wl[23], wl};
  assign cneg_x = -cx;
  assign cneg_y = -cy;
  assign c_val = cneg ? cneg_x[32:0] : cx[32:0];
  assign s_val = cneg ? cneg_y[32:0] : cy[32:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_init = '0;
    mul_nb = '0;
    unique case (cmd.sel)
      M_LIN: begin
        mul_a = {{39{sum_lr[24]}}, sum_lr};
        mul_b = {17'b0, radius};
        mul_init = 64'd1 << 16;
        mul_nb = NB_W'(17);
      end
      M_DV: begin
        mul_a = {{39{dif_lr[24]}}, dif_lr};
        mul_b = {17'b0, radius};
        mul_init = 64'd1 << 15;
        mul_nb = NB_W'(17);
      end
      M_ANG: begin
        mul_a = {{38{dv[25]}}, dv};
        mul_b = {9'b0, inv_sep};
        mul_init = 64'd1 << 15;
        mul_nb = NB_W'(25);
      end
      M_RAD: begin
        mul_a = {{30{ang[33]}}, ang};
        mul_b = {17'b0, dt};
        mul_init = '0;
        mul_nb = NB_W'(17);
      end
      M_DFULL: begin
        mul_a = rad;
        mul_b = K_FULL;
        mul_init = 64'd1 << 31;
        mul_nb = NB_W'(31);
      end
      M_DHALF: begin
        mul_a = rad;
        mul_b = K_HALF;
        mul_init = 64'd1 << 31;
        mul_nb = NB_W'(30);
      end
      M_VX: begin
        mul_a = {{39{lin[24]}}, lin};
        mul_b = c_val;
        mul_init = 64'd1 << 13;
        mul_nb = NB_W'(33);
      end
      M_DX: begin
        mul_a = {{20{vx[43]}}, vx};
        mul_b = {17'b0, dt};
        mul_init = 64'd1 << 31;
        mul_nb = NB_W'(17);
      end
      M_VY: begin
        mul_a = {{39{lin[24]}}, lin};
        mul_b = s_val;
        mul_init = 64'd1 << 13;
        mul_nb = NB_W'(33);
      end
      M_DY: begin
        mul_a = {{20{vy[43]}}, vy};
        mul_b = {17'b0, dt};
        mul_init = 64'd1 << 31;
        mul_nb = NB_W'(17);
      end
      default: ;
    endcase
  end

  ddo_mul u_mul (
    .clk(clk),
    .rst(rst),
    .start(cmd.mul_start),
    .a(mul_a),
    .b(mul_b),
    .init(mul_init),
    .nbits(mul_nb),
    .p(mul_p),
    .done(mul_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wl <= dband(left_wheel_speed, db_offset, db_width);
      wr <= dband(right_wheel_speed, db_offset, db_width);
      dt <= time_step;
    end
    if (cmd.capture) begin
      unique case (cmd.sel)
        M_LIN: lin <= mul_p[41:17];
        M_DV: dv <= mul_p[41:16];
        M_ANG: ang <= mul_p[49:16];
        M_RAD: rad <= mul_p;
        M_DFULL: dfull <= mul_p[63:32];
        M_DHALF: dhalf <= mul_p[63:32];
        M_VX: vx <= mul_p[57:14];
        M_DX: dx <= mul_p[59:32];
        M_VY: vy <= mul_p[57:14];
        M_DY: dy <= mul_p[59:32];
        default: ;
      endcase
    end
  end

  // cordic rotation
  logic signed [31:0] zmid;
  logic signed [33:0] zext, xs, ys, at;

  assign zmid = heading + dhalf;
  assign zext = {{2{zmid[31]}}, zmid};
  assign xs = cx >>> cmd.iter;
  assign ys = cy >>> cmd.iter;
  assign at = {2'b0, atan_bam(cmd.iter)};

  always_ff @(posedge clk) begin
    if (cmd.cordic_init) begin
      cx <= CORDIC_START;
      cy <= '0;
      if (zext > 34'sd1073741824) begin
        cz <= zext - 34'sd2147483648;
        cneg <= 1'b1;
      end else if (zext < -34'sd1073741824) begin
        cz <= zext + 34'sd2147483648;
        cneg <= 1'b1;
      end else begin
        cz <= zext;
        cneg <= 1'b0;
      end
    end else if (cmd.cordic_step) begin
      if (!cz[33]) begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - at;
      end else begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + at;
      end
    end
  end

  // pose update: x and y saturate, heading wraps
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                 input logic signed [27:0] d);
    logic signed [32:0] v;
    v = {p[31], p} + {{5{d[27]}}, d};
    if (v[32] != v[31]) return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x <= '0;
      pose_y <= '0;
      heading <= '0;
    end else if (cmd.commit) begin
      pose_x <= sat_add(pose_x, dx);
      pose_y <= sat_add(pose_y, dy);
      heading <= heading + dfull;
    end
  end

endmodule

// File: rtl/core/ddo_ctrl.sv
module ddo_ctrl #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  logic mul_done,
  output ddo_pkg::ddo_cmd_t cmd
);
  import ddo_pkg::*;

  state_t state, state_next;
  mul_sel_t sel, sel_next;
  logic [ITER_W-1:0] iter, iter_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel <= M_LIN;
      iter <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      sel <= sel_next;
      iter <= iter_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    sel_next = sel;
    iter_next = iter;
    out_valid_next = out_valid && out_stall;
    cmd = '0;
    cmd.sel = sel;
    cmd.iter = iter;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          sel_next = M_LIN;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_start = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (mul_done) begin
          cmd.capture = 1'b1;
          if (sel == M_DHALF) state_next = S_CORDIC_INIT;
          else if (sel == M_DY) state_next = S_COMMIT;
          else begin
            sel_next = mul_sel_t'(sel + 4'd1);
            state_next = S_MUL;
          end
        end
      end
      S_CORDIC_INIT: begin
        cmd.cordic_init = 1'b1;
        iter_next = '0;
        state_next = S_CORDIC;
      end
      S_CORDIC: begin
        cmd.cordic_step = 1'b1;
        iter_next = iter + ITER_W'(1);
        if (iter == ITER_W'(TRIG_ITERATIONS - 1)) begin
          sel_next = M_VX;
          state_next = S_MUL;
        end
      end
      S_COMMIT: begin
        if (!out_valid || !out_stall) begin
          cmd.commit = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_MUL && sel == M_LIN))
    else $error("accepted request did not start the multiply chain");
  a_cordic_sel: assert property (@(posedge clk) disable iff (rst)
    cmd.cordic_step |-> (sel == M_DHALF))
    else $error("cordic step out of sequence");
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_WAIT))
    else $error("multiply finished outside wait");
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> !$past(cmd.commit))
    else $error("pose overwritten while result held");

endmodule

// File: rtl/core/diff_drive_odometry.sv
// Differential-drive odometry with midpoint pose integration. Each accepted
// request (wheel speeds and time step) produces one result with the updated
// pose. The next request can be taken in the same cycle as the result
// appears. The work is done by a single bit-serial multiplier, one operand
// bit per cycle over ten chained products, plus one CORDIC iteration per cycle.
// The input side is stalled while a request is in progress; a finished
// result is held in the output register while the next request is taken.
// Configuration registers must be written while the block is idle.
module diff_drive_odometry #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [23:0] left_wheel_speed,
  input  logic signed [23:0] right_wheel_speed,
  input  logic [15:0] time_step,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [31:0] pose_x,
  output logic signed [31:0] pose_y,
  output logic signed [31:0] heading,
  input  logic cfg_wen,
  input  logic [1:0] cfg_index,
  input  logic [23:0] cfg_data
);
  import ddo_pkg::*;

  ddo_cmd_t cmd;
  logic mul_done;

  ddo_ctrl #(
    .TRIG_ITERATIONS(TRIG_ITERATIONS)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .mul_done(mul_done),
    .cmd(cmd)
  );

  ddo_datapath u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .mul_done(mul_done),
    .cfg_wen(cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .left_wheel_speed(left_wheel_speed),
    .right_wheel_speed(right_wheel_speed),
    .time_step(time_step),
    .pose_x(pose_x),
    .pose_y(pose_y),
    .heading(heading)
  );

endmodule
